@@ rtl/core/haptic_pattern_player_defines.svh @@
// Assertion macros for the haptic pattern player.
// Used by the top level only; no other dependencies.
`ifndef HAPTIC_PATTERN_PLAYER_DEFINES_SVH
`define HAPTIC_PATTERN_PLAYER_DEFINES_SVH

// Condition must hold on every edge outside reset.
`define HPP_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define HPP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the following edge.
`define HPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hpp_pkg.sv @@
// Shared types, constants and the pattern table of the haptic pattern player.
// No dependencies.
package hpp_pkg;

  localparam int PAT_W             = 3;
  localparam int MS_W              = 7;
  localparam int STEP_W            = 3;
  localparam int STEP_CNT_W        = STEP_W + 1;
  localparam int TABLE_ROWS        = 7;
  localparam int TABLE_STEPS       = 6;
  localparam int PATTERN_COUNT     = 7;
  localparam int MAX_PATTERN_STEPS = 6;

  typedef enum logic {
    CMD_PLAY = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PAT_W-1:0] pattern;
  } cmd_t;

  typedef struct packed {
    logic motor_on;
    logic dropped;
    logic busy;
  } result_t;

  typedef struct packed {
    logic enable;
    logic playing;
    logic motor;
    logic in_off;
  } player_status_t;

  // Raw number of steps in each pattern row.
  function automatic logic [STEP_CNT_W-1:0] raw_len(logic [PAT_W-1:0] p);
    logic [STEP_CNT_W-1:0] n;
    n = '0;
    unique case (p)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5: n = STEP_CNT_W'(1);
      3'd6:                               n = STEP_CNT_W'(3);
      default:                            n = '0;
    endcase
    return n;
  endfunction

  // Step count, clipped to the table width and the play limit.
  function automatic logic [STEP_CNT_W-1:0] steps_of(logic [PAT_W-1:0] p);
    int n;
    n = int'(raw_len(p));
    if (n > TABLE_STEPS) n = TABLE_STEPS;
    if (n > MAX_PATTERN_STEPS) n = MAX_PATTERN_STEPS;
    return STEP_CNT_W'(n);
  endfunction

  function automatic logic [MS_W-1:0] step_on(logic [PAT_W-1:0] p, logic [STEP_W-1:0] s);
    logic [MS_W-1:0] v;
    v = '0;
    unique case (p)
      3'd0:    v = (s == '0) ? MS_W'(60)  : '0;
      3'd1:    v = (s == '0) ? MS_W'(40)  : '0;
      3'd2:    v = (s == '0) ? MS_W'(30)  : '0;
      3'd3:    v = (s == '0) ? MS_W'(60)  : '0;
      3'd4:    v = (s == '0) ? MS_W'(100) : '0;
      3'd5:    v = (s == '0) ? MS_W'(25)  : '0;
      3'd6:    v = (s < STEP_W'(3)) ? MS_W'(80) : '0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [MS_W-1:0] step_off(logic [PAT_W-1:0] p, logic [STEP_W-1:0] s);
    logic [MS_W-1:0] v;
    v = '0;
    unique case (p)
      3'd6:    v = (s < STEP_W'(2)) ? MS_W'(80) : '0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic pattern_ok(logic [PAT_W-1:0] p);
    return (int'(p) < PATTERN_COUNT) && (int'(p) < TABLE_ROWS);
  endfunction

endpackage

@@ rtl/core/haptic_pattern_player.sv @@
// Top level of the haptic pattern player: front end, sequencer, result queue.
// Depends on hpp_pkg, hpp_front, hpp_player, hpp_res_q and the defines header.
//
//  channel   handshake        beat contents
//  -------   ---------------  ---------------------------------
//  input     push / full      op, pattern
//  result    empty / pop      motor_on, dropped, busy_res
//  config    cfg_we           cfg_wdata (enable)
//
// One beat in and one result out per cycle, sustained while the consumer pops.
// A beat is registered in the command queue, the sequencer works out its
// result at the queue head, and the result queue registers it for the
// result ports. Reset is synchronous; enable comes up at 1, the request
// queue holds no entries and its store needs no clearing. A stalled consumer
// fills the result queue, then the command queue, then raises full.
`include "haptic_pattern_player_defines.svh"

module haptic_pattern_player
  import hpp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             op,
  input  logic [PAT_W-1:0] pattern,
  output logic             empty,
  input  logic             pop,
  output logic             motor_on,
  output logic             dropped,
  output logic             busy_res,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  logic           cmd_valid;
  cmd_t           cmd;
  logic           cmd_take;
  logic           res_ready;
  logic           res_valid;
  result_t        res;
  result_t        res_out;
  player_status_t status;

  // Accept and tag beats; hold them until the sequencer takes them.
  hpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .pattern  (pattern),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  // Execute one command per cycle while the result queue has room.
  hpp_player #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_player (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res      (res),
    .status   (status)
  );

  // Hold results until the consumer pops them.
  hpp_res_q u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(res_valid),
    .wr_data (res),
    .wr_ready(res_ready),
    .empty   (empty),
    .pop     (pop),
    .rd_data (res_out)
  );

  assign motor_on = res_out.motor_on;
  assign dropped  = res_out.dropped;
  assign busy_res = res_out.busy;

  // The motor never runs, and no phase is pending, outside a pattern.
  `HPP_ASSERT_IMPLIES(a_idle_quiet, clk, rst, !status.playing, !status.motor && !status.in_off, "motor or off phase active while idle")
  // A disabled player never plays.
  `HPP_ASSERT_IMPLIES(a_disabled_idle, clk, rst, !status.enable, !status.playing, "playing while disabled")
  // Writing enable low stops playback on the next edge.
  `HPP_ASSERT_NEXT(a_disable_stops, clk, rst, cfg_we && !cfg_wdata, !status.playing && !status.motor, "disable did not stop playback")
  // A waiting result that reports idle never drives the motor.
  `HPP_ASSERT_IMPLIES(a_result_idle, clk, rst, !empty && !busy_res, !motor_on, "result drives motor while idle")

endmodule

@@ rtl/core/hpp_front.sv @@
// Front end: accepts items, tags them as play request or tick, holds them
// in a two-slot command queue. Depends on hpp_pkg.
module hpp_front
  import hpp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             op,
  input  logic [PAT_W-1:0] pattern,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);

  localparam int SLOTS = 2;

  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       accept;
  cmd_t       slot [SLOTS];

  assign full      = (cnt == 2'(SLOTS));
  assign accept    = push && !full;
  assign cmd_valid = (cnt != '0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (cmd_take) rd_ptr <= ~rd_ptr;
      unique case ({accept, cmd_take})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr].kind    <= op ? CMD_TICK : CMD_PLAY;
      slot[wr_ptr].pattern <= pattern;
    end
  end

endmodule

@@ rtl/core/hpp_player.sv @@
// Back end: request queue, pattern sequencer and enable register; depends on
// hpp_pkg. Executes one command per cycle while the result queue has room.
module hpp_player
  import hpp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
)
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           cmd_valid,
  input  cmd_t           cmd,
  output logic           cmd_take,
  input  logic           res_ready,
  output logic           res_valid,
  output result_t        res,
  output player_status_t status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              found;
    logic [STEP_W-1:0] idx;
    logic              motor;
    logic              off;
    logic [MS_W-1:0]   ms;
  } scan_t;

  // Find the first step at or after 'first' with a nonzero phase.
  function automatic scan_t scan_from(logic [PAT_W-1:0] p, logic [STEP_CNT_W-1:0] first);
    scan_t                 r;
    logic [STEP_CNT_W-1:0] n;
    logic [MS_W-1:0]       on_ms;
    logic [MS_W-1:0]       off_ms;
    r = '0;
    n = steps_of(p);
    for (int j = 0; j < TABLE_STEPS; j++) begin
      on_ms  = step_on(p, STEP_W'(j));
      off_ms = step_off(p, STEP_W'(j));
      if (!r.found && STEP_CNT_W'(j) >= first && STEP_CNT_W'(j) < n) begin
        if (on_ms != '0) begin
          r = '{found: 1'b1, idx: STEP_W'(j), motor: 1'b1, off: 1'b0, ms: on_ms};
        end else if (off_ms != '0) begin
          r = '{found: 1'b1, idx: STEP_W'(j), motor: 1'b0, off: 1'b1, ms: off_ms};
        end
      end
    end
    return r;
  endfunction

  logic                  enable,   enable_next;
  logic [AW-1:0]         head,     head_next;
  logic [AW-1:0]         tail,     tail_next;
  logic [CW-1:0]         count,    count_next;
  logic                  playing,  playing_next;
  logic [PAT_W-1:0]      cur_pat,  cur_pat_next;
  logic [STEP_W-1:0]     step_idx, step_idx_next;
  logic                  in_off,   in_off_next;
  logic [MS_W-1:0]       ms_left,  ms_left_next;
  logic                  motor,    motor_next;

  logic [PAT_W-1:0]      mem [QUEUE_DEPTH];
  logic [PAT_W-1:0]      head_data;

  logic                  fire;
  logic                  we;
  logic                  refused;
  logic                  do_scan;
  logic [PAT_W-1:0]      scan_pat;
  logic [STEP_CNT_W-1:0] scan_first;
  scan_t                 sc;
  logic [MS_W-1:0]       ms_dec;
  logic [MS_W-1:0]       off_ms;

  assign fire     = cmd_valid && res_ready;
  assign cmd_take = fire;

  always_comb begin
    enable_next   = enable;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    playing_next  = playing;
    cur_pat_next  = cur_pat;
    step_idx_next = step_idx;
    in_off_next   = in_off;
    ms_left_next  = ms_left;
    motor_next    = motor;
    we            = 1'b0;
    refused       = 1'b0;
    do_scan       = 1'b0;
    scan_pat      = cur_pat;
    scan_first    = '0;
    ms_dec        = (ms_left != '0) ? ms_left - 1'b1 : ms_left;
    off_ms        = step_off(cur_pat, step_idx);

    if (fire) begin
      unique case (cmd.kind)
        CMD_PLAY: begin
          if (!enable || count == CW'(QUEUE_DEPTH)) begin
            refused = 1'b1;
          end else begin
            we         = 1'b1;
            tail_next  = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
        end
        CMD_TICK: begin
          if (!playing) begin
            if (count != '0) begin
              head_next  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
              count_next = count - 1'b1;
              if (enable && pattern_ok(head_data)) begin
                playing_next = 1'b1;
                cur_pat_next = head_data;
                do_scan      = 1'b1;
                scan_pat     = head_data;
              end
            end
          end else begin
            ms_left_next = ms_dec;
            if (ms_dec == '0) begin
              do_scan    = 1'b1;
              scan_first = {1'b0, step_idx} + 1'b1;
              if (!in_off) begin
                motor_next = 1'b0;
                if (off_ms != '0) begin
                  in_off_next  = 1'b1;
                  ms_left_next = off_ms;
                  do_scan      = 1'b0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    sc = scan_from(scan_pat, scan_first);
    if (do_scan) begin
      if (sc.found) begin
        step_idx_next = sc.idx;
        motor_next    = sc.motor;
        in_off_next   = sc.off;
        ms_left_next  = sc.ms;
      end else begin
        playing_next  = 1'b0;
        motor_next    = 1'b0;
        in_off_next   = 1'b0;
        ms_left_next  = '0;
        step_idx_next = '0;
      end
    end

    // Disabling stops playback at once.
    if (cfg_we) begin
      enable_next = cfg_wdata;
      if (!cfg_wdata) begin
        playing_next  = 1'b0;
        motor_next    = 1'b0;
        in_off_next   = 1'b0;
        ms_left_next  = '0;
        step_idx_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b1;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      playing  <= 1'b0;
      cur_pat  <= '0;
      step_idx <= '0;
      in_off   <= 1'b0;
      ms_left  <= '0;
      motor    <= 1'b0;
    end else begin
      enable   <= enable_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      playing  <= playing_next;
      cur_pat  <= cur_pat_next;
      step_idx <= step_idx_next;
      in_off   <= in_off_next;
      ms_left  <= ms_left_next;
      motor    <= motor_next;
    end
  end

  // Request store; read port tracks the next head, with write bypass.
  always_ff @(posedge clk) begin
    if (we) mem[tail] <= cmd.pattern;
    if (we && tail == head_next) begin
      head_data <= cmd.pattern;
    end else begin
      head_data <= mem[head_next];
    end
  end

  assign res_valid    = fire;
  assign res.motor_on = motor_next;
  assign res.dropped  = refused;
  assign res.busy     = playing_next;

  assign status = '{enable: enable, playing: playing, motor: motor, in_off: in_off};

endmodule

@@ rtl/core/hpp_res_q.sv @@
// Result queue: two-slot buffer between the sequencer and the consumer.
// Depends on hpp_pkg.
module hpp_res_q
  import hpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_valid,
  input  result_t wr_data,
  output logic    wr_ready,
  output logic    empty,
  input  logic    pop,
  output result_t rd_data
);

  localparam int SLOTS = 2;

  logic [1:0] cnt;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       wr;
  logic       rd;
  result_t    slot [SLOTS];

  assign wr_ready = (cnt != 2'(SLOTS));
  assign wr       = wr_valid && wr_ready;
  assign empty    = (cnt == '0);
  assign rd       = pop && !empty;
  assign rd_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      unique case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot[wr_ptr] <= wr_data;
  end

endmodule
